/* src/stk_pkg.sv */
package stk_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic  accept;
    func_e func;
    logic  read_done;
    logic  scan_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic scan_end;
  } sts_t;

endpackage

/* src/stk_ctrl.sv */
module stk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    func_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stk_pkg::cmd_t cmd_o,
  input  stk_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic           ovalid_q, ovalid_d;
  logic           out_free;
  logic           accept;
  logic           out_load;
  stk_pkg::func_e func;

  assign func       = stk_pkg::func_e'(func_i);
  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    out_load         = 1'b0;
    cmd_o.accept     = accept;
    cmd_o.func       = func;
    cmd_o.read_done  = 1'b0;
    cmd_o.scan_step  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            stk_pkg::FUNC_PUSH: out_load = 1'b1;
            stk_pkg::FUNC_POP, stk_pkg::FUNC_PEEK: begin
              if (sts_i.empty) begin
                out_load = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            stk_pkg::FUNC_REMOVE: begin
              if (sts_i.empty) begin
                out_load = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.read_done = 1'b1;
        out_load        = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ovalid_d    = out_load || (ovalid_q && !out_ready_i);
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

/* src/stk_dpath.sv */
module stk_dpath #(
  parameter int unsigned DEPTH = stk_pkg::DepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [stk_pkg::ValueW-1:0]  value_i,
  input  stk_pkg::cmd_t                      cmd_i,
  output stk_pkg::sts_t                      sts_o,
  output logic [1:0]                         status_o,
  output logic signed [stk_pkg::ValueW-1:0]  top_value_o,
  output logic [stk_pkg::CountW-1:0]         entry_count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = stk_pkg::ValueW;

  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] rdata_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [VW-1:0] val_q, val_d;
  logic          pop_q, pop_d;
  stk_pkg::status_e status_q, status_d;
  logic [VW-1:0] top_q, top_d;

  logic          empty;
  logic          full;
  logic          scan_end;
  logic          keep;
  logic [CW-1:0] top_idx;
  logic [CW-1:0] new_cnt;

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CW'(DEPTH));
  assign scan_end = (rd_q == cnt_q);
  assign keep     = (rdata_q != val_q);
  assign top_idx  = cnt_q - CW'(1);
  assign new_cnt  = wr_q + CW'(keep);

  assign sts_o.empty    = empty;
  assign sts_o.scan_end = scan_end;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    val_d     = val_q;
    pop_d     = pop_q;
    status_d  = status_q;
    top_d     = top_q;
    if (cmd_i.accept) begin
      val_d = value_i;
      pop_d = (cmd_i.func == stk_pkg::FUNC_POP);
      top_d = '0;
      unique case (cmd_i.func)
        stk_pkg::FUNC_PUSH: begin
          if (full) begin
            status_d = stk_pkg::ST_FULL;
          end else begin
            status_d  = stk_pkg::ST_OK;
            mem_we    = 1'b1;
            mem_waddr = cnt_q[AW-1:0];
            mem_wdata = value_i;
            cnt_d     = cnt_q + CW'(1);
          end
        end
        stk_pkg::FUNC_POP, stk_pkg::FUNC_PEEK: begin
          status_d  = stk_pkg::ST_EMPTY;
          mem_re    = !empty;
          mem_raddr = top_idx[AW-1:0];
        end
        stk_pkg::FUNC_REMOVE: begin
          status_d  = stk_pkg::ST_NOTFOUND;
          rd_d      = CW'(1);
          wr_d      = '0;
          mem_re    = !empty;
          mem_raddr = '0;
        end
      endcase
    end else if (cmd_i.read_done) begin
      top_d    = rdata_q;
      status_d = stk_pkg::ST_OK;
      if (pop_q) begin
        cnt_d = top_idx;
      end
    end else if (cmd_i.scan_step) begin
      // rdata_q holds entry rd_q-1, kept entries slide down to wr_q
      if (keep) begin
        mem_we    = 1'b1;
        mem_waddr = wr_q[AW-1:0];
        mem_wdata = rdata_q;
        wr_d      = wr_q + CW'(1);
      end
      if (scan_end) begin
        cnt_d    = new_cnt;
        status_d = (new_cnt == cnt_q) ? stk_pkg::ST_NOTFOUND : stk_pkg::ST_OK;
      end else begin
        mem_re    = 1'b1;
        mem_raddr = rd_q[AW-1:0];
        rd_d      = rd_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    wr_q     <= wr_d;
    val_q    <= val_d;
    pop_q    <= pop_d;
    status_q <= status_d;
    top_q    <= top_d;
  end

  assign status_o      = status_q;
  assign top_value_o   = top_q;
  assign entry_count_o = stk_pkg::CountW'(cnt_q);
  assign is_empty_o    = empty;
  assign is_full_o     = full;

endmodule

/* src/stack_with_value_removal.sv */
// push, and pop, peek or remove on an empty stack, give their result in the cycle after
// the item is taken; pop and peek with entries first pass S_READ (registered store read);
// remove on n entries steps through S_SCAN, one store entry read and compared per cycle
// throughput: one push per cycle unless the output stalls; no item is taken in S_READ/S_SCAN
// reset clears the entry count and the output valid; store contents stay undefined
module stack_with_value_removal #(
  parameter int unsigned DEPTH = stk_pkg::DepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic signed [stk_pkg::ValueW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [stk_pkg::ValueW-1:0]  top_value_o,
  output logic [stk_pkg::CountW-1:0]         entry_count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  stk_pkg::cmd_t cmd;
  stk_pkg::sts_t sts;

  stk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  stk_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .top_value_o   (top_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule

/* src/stk_chk.sv */
module stk_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         func_i,
  input logic signed [stk_pkg::ValueW-1:0]  value_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [1:0]                         status_o,
  input logic signed [stk_pkg::ValueW-1:0]  top_value_o,
  input logic [stk_pkg::CountW-1:0]         entry_count_o,
  input logic                               is_empty_o,
  input logic                               is_full_o
);

  logic [1:0] st_ok;

  assign st_ok = stk_pkg::ST_OK;

  // a failed request never carries a value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != st_ok) |-> (top_value_o == '0))
    else $error("failed request with nonzero value");

  // empty stack shows a zero count and is never full
  a_empty_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (entry_count_o == '0) && !is_full_o)
    else $error("empty flag inconsistent with count or full");

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(top_value_o) && $stable(entry_count_o)
      && $stable(is_empty_o) && $stable(is_full_o))
    else $error("output changed while stalled");

  // no new item is taken while a result waits and is not taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result blocked");

endmodule

bind stack_with_value_removal stk_chk u_stk_chk (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import stk_pkg::*;

  localparam int unsigned Depth     = DepthDef;
  localparam int unsigned RandItems = 1700;
  localparam int unsigned NumRows   = 20;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] top;
    logic [4:0]         count;
    logic               empty;
    logic               full;
  } stack_result_t;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] value;
    logic [7:0]         reps;
    logic               typed;
    stack_result_t      want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         func_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic signed [31:0] top_value_o;
  logic [4:0]         entry_count_o;
  logic               is_empty_o;
  logic               is_full_o;

  stack_with_value_removal #(
    .DEPTH(Depth)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .top_value_o,
    .entry_count_o,
    .is_empty_o,
    .is_full_o
  );

  // predictor state
  logic signed [31:0] stack_mem [Depth];
  int unsigned        stack_fill;

  stack_result_t expected_results [$];
  int unsigned   fault_count;

  logic          row_typed;
  stack_result_t row_want;
  logic          send_calm;
  logic          sink_calm;
  logic          hold_sink;

  logic signed [31:0] value_pool [8];

  // reading the table top down: empty stack, extremes, fill to full, remove with compaction
  stim_row_t directed_rows [NumRows] = '{
    '{FUNC_POP,    32'hdeadbeef, 8'd1,  1'b1, '{ST_EMPTY,    32'h0, 5'd0,  1'b1, 1'b0}},
    '{FUNC_PEEK,   32'h12345678, 8'd1,  1'b1, '{ST_EMPTY,    32'h0, 5'd0,  1'b1, 1'b0}},
    '{FUNC_REMOVE, 32'h00000000, 8'd1,  1'b1, '{ST_NOTFOUND, 32'h0, 5'd0,  1'b1, 1'b0}},
    '{FUNC_PUSH,   32'h7fffffff, 8'd1,  1'b1, '{ST_OK,       32'h0, 5'd1,  1'b0, 1'b0}},
    '{FUNC_PUSH,   32'h80000000, 8'd1,  1'b1, '{ST_OK,       32'h0, 5'd2,  1'b0, 1'b0}},
    '{FUNC_PEEK,   32'hffffffff, 8'd1,  1'b1, '{ST_OK, 32'h80000000, 5'd2, 1'b0, 1'b0}},
    '{FUNC_PUSH,   32'hffffffff, 8'd1,  1'b0, '0},
    '{FUNC_PUSH,   32'h00000000, 8'd1,  1'b0, '0},
    '{FUNC_PUSH,   32'h0000002a, 8'd11, 1'b0, '0},
    '{FUNC_PUSH,   32'h0000002a, 8'd1,  1'b1, '{ST_OK,       32'h0, 5'd16, 1'b0, 1'b1}},
    '{FUNC_PUSH,   32'h00000001, 8'd1,  1'b1, '{ST_FULL,     32'h0, 5'd16, 1'b0, 1'b1}},
    '{FUNC_PEEK,   32'h00000000, 8'd1,  1'b1, '{ST_OK,      32'h2a, 5'd16, 1'b0, 1'b1}},
    '{FUNC_REMOVE, 32'h0000002a, 8'd1,  1'b1, '{ST_OK,       32'h0, 5'd4,  1'b0, 1'b0}},
    '{FUNC_REMOVE, 32'h00012345, 8'd1,  1'b1, '{ST_NOTFOUND, 32'h0, 5'd4,  1'b0, 1'b0}},
    '{FUNC_REMOVE, 32'h7fffffff, 8'd1,  1'b0, '0},
    '{FUNC_POP,    32'hdeadbeef, 8'd1,  1'b0, '0},
    '{FUNC_POP,    32'haaaaaaaa, 8'd1,  1'b0, '0},
    '{FUNC_PEEK,   32'h55555555, 8'd1,  1'b0, '0},
    '{FUNC_REMOVE, 32'h80000000, 8'd1,  1'b1, '{ST_OK,       32'h0, 5'd0,  1'b1, 1'b0}},
    '{FUNC_POP,    32'h00000000, 8'd1,  1'b1, '{ST_EMPTY,    32'h0, 5'd0,  1'b1, 1'b0}}
  };

  function automatic stack_result_t apply_stack_op(func_e f, logic signed [31:0] v);
    stack_result_t r;
    int unsigned   kept;
    r        = '0;
    r.status = ST_OK;
    case (f)
      FUNC_PUSH: begin
        if (stack_fill >= Depth) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = v;
          stack_fill++;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top = stack_mem[stack_fill-1];
          if (f == FUNC_POP) stack_fill--;
        end
      end
      default: begin
        kept = 0;
        for (int unsigned i = 0; i < stack_fill; i++) begin
          if (stack_mem[i] !== v) begin
            stack_mem[kept] = stack_mem[i];
            kept++;
          end
        end
        if (kept == stack_fill) r.status = ST_NOTFOUND;
        stack_fill = kept;
      end
    endcase
    r.count = stack_fill[4:0];
    r.empty = (stack_fill == 0);
    r.full  = (stack_fill >= Depth);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // result checking at each taken result and prediction at each accepted item
  always @(posedge clk_i) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_e'(status_o), top_value_o, entry_count_o, is_empty_o, is_full_o};
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with nothing expected: st %0d top %0d cnt %0d e %0b f %0b",
                     $time, status_o, top_value_o, entry_count_o, is_empty_o, is_full_o);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.top !== want.top ||
              got.count !== want.count || got.empty !== want.empty ||
              got.full !== want.full) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"%0t: mismatch exp st %0d top %0d cnt %0d e %0b f %0b,",
                        " got st %0d top %0d cnt %0d e %0b f %0b"}, $time,
                       want.status, want.top, want.count, want.empty, want.full,
                       status_o, top_value_o, entry_count_o, is_empty_o, is_full_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = apply_stack_op(func_e'(func_i), value_i);
        expected_results.push_back(row_typed ? row_want : want);
      end
    end
  end

  task automatic offer_item(input func_e f, input logic signed [31:0] v, input logic typed,
                            input stack_result_t want);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = f;
    value_i    = v;
    row_typed  = typed;
    row_want   = want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    int unsigned   mix;
    int unsigned   push_share;
    int unsigned   sel;
    func_e         f;
    logic signed [31:0] v;
    in_valid_i  = 1'b0;
    func_i      = FUNC_PUSH;
    value_i     = '0;
    row_typed   = 1'b0;
    row_want    = '0;
    send_calm   = 1'b0;
    sink_calm   = 1'b0;
    hold_sink   = 1'b0;
    stack_fill  = 0;
    fault_count = 0;
    mix         = 0;
    value_pool  = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                    $urandom, $urandom, $urandom, $urandom};
    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      for (int unsigned k = 0; k < directed_rows[i].reps; k++)
        offer_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].want);
    end

    for (int unsigned k = 0; k < RandItems; k++) begin
      if (k % 64 == 0) begin
        mix       = $urandom_range(0, 2);
        send_calm = ($urandom_range(0, 3) == 0);
      end
      // receiver stalls for a long stretch while items keep coming
      if (k == 300) hold_sink = 1'b1;
      // drain completely before going on
      if (k == 900) begin
        in_valid_i = 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      push_share = (mix == 0) ? 60 : (mix == 1) ? 25 : 45;
      sel = $urandom_range(0, 99);
      if (sel < push_share) f = FUNC_PUSH;
      else if (sel < push_share + 20) f = FUNC_POP;
      else if (sel < push_share + 32) f = FUNC_PEEK;
      else f = FUNC_REMOVE;
      v = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)] : $urandom;
      offer_item(f, v, 1'b0, '0);
    end
    in_valid_i = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ready_i = 1'b0;
    taken       = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        hold_sink = 1'b0;
        stall     = 400;
      end else begin
        stall = sink_calm ? 0 : $urandom_range(0, 10);
      end
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 50 == 0) sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
src/stk_pkg.sv
src/stk_ctrl.sv
src/stk_dpath.sv
src/stack_with_value_removal.sv
src/stk_chk.sv
dv/tb_top.sv
